// ===== design/srs_pkg.sv =====
// Shared types, codes and constants of the timed row sowing sequencer.
package srs_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PLANT = 2'd2
    } mode_t;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_KEY    = 2'd1;
    localparam logic [1:0] ACT_BUTTON = 2'd2;

    localparam logic [2:0] ST_NONE         = 3'd0;
    localparam logic [2:0] ST_KEY_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_KEY_INVALID  = 3'd2;
    localparam logic [2:0] ST_NEED_NUMBER  = 3'd3;
    localparam logic [2:0] ST_KEY_IGNORED  = 3'd4;
    localparam logic [2:0] ST_ROWS_DONE    = 3'd5;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TICKS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANT_TICKS = 1'd1;

    localparam logic [15:0] RUN_TICKS_RESET   = 16'd500;
    localparam logic [15:0] PLANT_TICKS_RESET = 16'd500;
    localparam logic [5:0]  FORWARD_BITS      = 6'h39;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] motor_drive;
        logic       led_green;
        logic [3:0] rows_left;
        logic       is_armed;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // 3x4 keypad: rows 0..2 and columns 0..2 give digits 1..9, else 0
    function automatic logic [3:0] key_digit(input logic [3:0] code);
        logic [3:0] row;
        logic [3:0] col;
        row = {2'b00, code[3:2]};
        col = {2'b00, code[1:0]};
        if (code[3:2] == 2'd3 || code[1:0] == 2'd3)
            key_digit = 4'd0;
        else
            key_digit = (row << 1) + row + col + 4'd1;
    endfunction

endpackage

// ===== design/srs_core.sv =====
// Mode state, phase and row counters, tick settings and per-beat next-state logic.
module srs_core
    import srs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_item_t   item,
    input  cfg_write_t cfg,
    output out_item_t  result
);

    mode_t       mode_reg, mode_next;
    logic [15:0] phase_reg, phase_next;
    logic [3:0]  cycles_reg, cycles_next;
    logic [3:0]  target_reg, target_next;
    logic        armed_reg, armed_next;
    logic        green_reg, green_next;
    logic [15:0] run_ticks_reg;
    logic [15:0] plant_ticks_reg;
    logic [2:0]  status;
    logic [15:0] phase_inc;
    logic [3:0]  cycles_inc;
    logic [3:0]  digit;

    assign phase_inc  = phase_reg + 16'd1;
    assign cycles_inc = cycles_reg + 4'd1;
    assign digit      = key_digit(item.key_code);

    always_comb
    begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        cycles_next = cycles_reg;
        target_next = target_reg;
        armed_next  = armed_reg;
        green_next  = green_reg;
        status      = ST_NONE;
        unique case (item.action)
            ACT_TICK:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    phase_next = phase_inc;
                    if (phase_inc >= run_ticks_reg)
                    begin
                        mode_next  = MODE_PLANT;
                        phase_next = 16'd0;
                    end
                end
                else if (mode_reg == MODE_PLANT)
                begin
                    phase_next = phase_inc;
                    if (phase_inc >= plant_ticks_reg)
                    begin
                        mode_next   = MODE_RUN;
                        phase_next  = 16'd0;
                        cycles_next = cycles_inc;
                        // last row finished: straight back to idle
                        if (target_reg != 4'd0 && cycles_inc >= target_reg)
                        begin
                            mode_next   = MODE_IDLE;
                            cycles_next = 4'd0;
                            target_next = 4'd0;
                            armed_next  = 1'b0;
                            status      = ST_ROWS_DONE;
                        end
                    end
                end
            end
            ACT_KEY:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    if (digit != 4'd0)
                    begin
                        target_next = digit;
                        armed_next  = 1'b1;
                        status      = ST_KEY_ACCEPTED;
                    end
                    else
                        status = ST_KEY_INVALID;
                end
                else
                    status = ST_KEY_IGNORED;
            end
            ACT_BUTTON:
            begin
                if (armed_reg)
                begin
                    if (mode_reg == MODE_IDLE)
                        mode_next = MODE_RUN;
                    else
                    begin
                        mode_next = MODE_IDLE;
                        if (target_reg != 4'd0)
                            target_next = target_reg - 4'd1;
                        armed_next = 1'b0;
                    end
                    phase_next  = 16'd0;
                    cycles_next = 4'd0;
                    if (target_next == 4'd0)
                        armed_next = 1'b0;
                    green_next = (mode_next == MODE_RUN);
                end
                else
                    status = ST_NEED_NUMBER;
            end
            default:
            begin
                status = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        result.mode        = mode_next;
        result.motor_drive = (mode_next == MODE_RUN) ? FORWARD_BITS : 6'd0;
        result.led_green   = green_next;
        result.rows_left   = target_next;
        result.is_armed    = armed_next;
        result.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            phase_reg  <= 16'd0;
            cycles_reg <= 4'd0;
            target_reg <= 4'd0;
            armed_reg  <= 1'b0;
            green_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            cycles_reg <= cycles_next;
            target_reg <= target_next;
            armed_reg  <= armed_next;
            green_reg  <= green_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_ticks_reg   <= RUN_TICKS_RESET;
            plant_ticks_reg <= PLANT_TICKS_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_RUN_TICKS:   run_ticks_reg   <= cfg.data;
                CFG_PLANT_TICKS: plant_ticks_reg <= cfg.data;
                default:         run_ticks_reg   <= run_ticks_reg;
            endcase
        end
    end

endmodule

// ===== design/timed_row_sowing_sequencer.sv =====
// Top level of the timed row sowing sequencer: input and result registers around the core.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one event per beat: a time
//   tick, a keypad strobe (with key_code) or a button press.
//   Output channel out_valid/out_ready/out_item returns exactly one result beat
//   per input beat, in order: mode, motor bits, LED, rows left, armed, status.
//   Config port cfg_we/cfg_index/cfg_data writes run_ticks (index 0) or
//   plant_ticks (index 1); write only while the block is idle.
//   Path: a beat accepted is held in the input register, and its result is
//   loaded into the result register when the core step fires (advance).
//   Throughput: one beat per cycle unless stalled, set by the single next-state
//   step of the core between the input register and the result register.
//   Reset: mode idle, counts and target cleared, disarmed, green LED off,
//   both tick settings back to 500, both channels empty.
//   Stall: while a result waits and out_ready is low, the result register holds;
//   one more beat is still taken into the input register, then in_ready drops.
module timed_row_sowing_sequencer
    import srs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       advance;
    out_item_t  result;
    cfg_write_t cfg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    srs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== tb/sv/timed_row_sowing_sequencer_test.sv =====
// Self-checking testbench for the timed row sowing sequencer: directed and random event streams.
`timescale 1ns / 100ps

module timed_row_sowing_sequencer_test;
    import srs_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state and its copy of the tick settings
    mode_t       pred_mode = MODE_IDLE;
    logic [15:0] pred_phase = '0;
    logic [3:0]  pred_rows_planted = '0;
    logic [3:0]  pred_target = '0;
    logic        pred_armed = 1'b0;
    logic        pred_led = 1'b0;
    logic [15:0] run_len = RUN_TICKS_RESET;
    logic [15:0] plant_len = PLANT_TICKS_RESET;

    out_item_t pending_reports[$];
    out_item_t want;
    int        fault_count = 0;
    int        events_sent = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;

    timed_row_sowing_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic in_item_t make_event(input logic [1:0] act, input logic [3:0] code);
        in_item_t ev;
        ev.action   = act;
        ev.key_code = code;
        return ev;
    endfunction

    // next state and report of the sequencer for one event
    task automatic predict_report(input in_item_t ev, output out_item_t rep);
        logic [2:0] st;
        logic [3:0] digit;
        st = ST_NONE;
        case (ev.action)
            ACT_TICK:
            begin
                if (pred_mode == MODE_RUN)
                begin
                    pred_phase = pred_phase + 16'd1;
                    if (pred_phase >= run_len)
                    begin
                        pred_mode  = MODE_PLANT;
                        pred_phase = '0;
                    end
                end
                else if (pred_mode == MODE_PLANT)
                begin
                    pred_phase = pred_phase + 16'd1;
                    if (pred_phase >= plant_len)
                    begin
                        pred_mode         = MODE_RUN;
                        pred_phase        = '0;
                        pred_rows_planted = pred_rows_planted + 4'd1;
                        if (pred_target != 0 && pred_rows_planted >= pred_target)
                        begin
                            pred_mode         = MODE_IDLE;
                            pred_rows_planted = '0;
                            pred_target       = '0;
                            pred_armed        = 1'b0;
                            st                = ST_ROWS_DONE;
                        end
                    end
                end
            end
            ACT_KEY:
            begin
                if (pred_mode == MODE_IDLE)
                begin
                    // keypad rows and columns 0..2 only; 3 in either is not a digit
                    if (ev.key_code[3:2] == 2'd3 || ev.key_code[1:0] == 2'd3)
                        digit = 4'd0;
                    else
                        digit = {2'b00, ev.key_code[3:2]} * 4'd3
                              + {2'b00, ev.key_code[1:0]} + 4'd1;
                    if (digit != 0)
                    begin
                        pred_target = digit;
                        pred_armed  = 1'b1;
                        st          = ST_KEY_ACCEPTED;
                    end
                    else
                        st = ST_KEY_INVALID;
                end
                else
                    st = ST_KEY_IGNORED;
            end
            ACT_BUTTON:
            begin
                if (pred_armed)
                begin
                    if (pred_mode == MODE_IDLE)
                        pred_mode = MODE_RUN;
                    else
                    begin
                        pred_mode = MODE_IDLE;
                        if (pred_target != 0)
                            pred_target = pred_target - 4'd1;
                        pred_armed = 1'b0;
                    end
                    pred_phase        = '0;
                    pred_rows_planted = '0;
                    if (pred_target == 0)
                        pred_armed = 1'b0;
                    pred_led = (pred_mode == MODE_RUN);
                end
                else
                    st = ST_NEED_NUMBER;
            end
            default:
            begin
            end
        endcase
        rep.mode        = pred_mode;
        rep.motor_drive = (pred_mode == MODE_RUN) ? FORWARD_BITS : 6'd0;
        rep.led_green   = pred_led;
        rep.rows_left   = pred_target;
        rep.is_armed    = pred_armed;
        rep.status      = st;
    endtask

    task automatic send_event(input in_item_t ev);
        out_item_t rep;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        predict_report(ev, rep);
        pending_reports.push_back(rep);
        events_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write enable is left high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_RUN_TICKS)
            run_len = value;
        else
            plant_len = value;
    endtask

    task automatic set_tick_lengths(input logic [15:0] run_v, input logic [15:0] plant_v);
        settle_idle();
        write_reg(CFG_RUN_TICKS, run_v);
        write_reg(CFG_PLANT_TICKS, plant_v);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no report pending");
                fault_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("mode", want.mode, out_item.mode);
                check_field("motor_drive", want.motor_drive, out_item.motor_drive);
                check_field("led_green", want.led_green, out_item.led_green);
                check_field("rows_left", want.rows_left, out_item.rows_left);
                check_field("is_armed", want.is_armed, out_item.is_armed);
                check_field("status", want.status, out_item.status);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // idle-mode keypad handling, unused action, start and stop by button
    task automatic test_keypad_and_button();
        send_event(make_event(ACT_TICK, 4'hF));
        send_event(make_event(2'd3, 4'hA));
        send_event(make_event(ACT_BUTTON, 4'h0));
        send_event(make_event(ACT_KEY, 4'hF));
        send_event(make_event(ACT_KEY, 4'h3));
        send_event(make_event(ACT_KEY, 4'h0));
        send_event(make_event(ACT_KEY, 4'hA));
        send_event(make_event(ACT_BUTTON, 4'h5));
        send_event(make_event(ACT_KEY, 4'h5));
        send_event(make_event(ACT_TICK, 4'h0));
        send_event(make_event(ACT_BUTTON, 4'h0));
    endtask

    // one-tick phases: two rows end straight in idle, LED left green
    task automatic test_row_completion();
        set_tick_lengths(16'd1, 16'd1);
        send_event(make_event(ACT_KEY, 4'h1));
        send_event(make_event(ACT_BUTTON, 4'h0));
        repeat (4) send_event(make_event(ACT_TICK, 4'h0));
        send_event(make_event(ACT_BUTTON, 4'h0));
    endtask

    task automatic test_longest_phases();
        set_tick_lengths(16'hFFFF, 16'hFFFF);
        send_event(make_event(ACT_KEY, 4'h9));
        send_event(make_event(ACT_BUTTON, 4'h0));
        send_event(make_event(ACT_TICK, 4'h0));
        send_event(make_event(2'd3, 4'hF));
        send_event(make_event(ACT_TICK, 4'h0));
        send_event(make_event(ACT_BUTTON, 4'h0));
    endtask

    // arm, start, then tick through the job or stop it part way
    task automatic run_row_job();
        logic [1:0] krow;
        logic [1:0] kcol;
        int         total;
        int         cap;
        int         n_ticks;
        bit         stop_early;
        if (pred_mode != MODE_IDLE)
            send_event(make_event(ACT_BUTTON, 4'($urandom_range(15))));
        if ($urandom_range(9) == 0)
            send_event(make_event(ACT_KEY, $urandom_range(1) ? {2'b11, 2'($urandom_range(3))}
                                                             : {2'($urandom_range(3)), 2'b11}));
        krow = 2'($urandom_range(2));
        kcol = 2'($urandom_range(2));
        send_event(make_event(ACT_KEY, {krow, kcol}));
        send_event(make_event(ACT_BUTTON, 4'($urandom_range(15))));
        total = int'(pred_target) * (int'(run_len) + int'(plant_len));
        stop_early = ($urandom_range(4) == 0) || (total > 150);
        cap = (total - 1 > 60) ? 60 : total - 1;
        n_ticks = stop_early ? int'($urandom_range(cap)) : total + int'($urandom_range(2));
        repeat (n_ticks)
        begin
            if ($urandom_range(19) == 0)
                send_event(make_event(2'($urandom_range(3)), 4'($urandom_range(15))));
            send_event(make_event(ACT_TICK, 4'($urandom_range(15))));
        end
        if (stop_early)
            send_event(make_event(ACT_BUTTON, 4'($urandom_range(15))));
    endtask

    function automatic logic [15:0] pick_tick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'hFFFF;
        else if (r < 20)
            return 16'd1;
        else if (r < 80)
            return 16'($urandom_range(5, 1));
        else
            return 16'($urandom_range(40, 6));
    endfunction

    task automatic test_random_jobs();
        int start;
        int pick;
        for (int stage = 0; stage < 3; stage++)
        begin
            send_gap_pct   = (stage == 0) ? 7 : (stage == 1) ? 76 : 0;
            recv_stall_pct = (stage == 0) ? 76 : (stage == 1) ? 7 : 0;
            set_tick_lengths(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)));
            start = events_sent;
            while (events_sent < start + 600)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    set_tick_lengths(pick_tick_length(), pick_tick_length());
                else if (pick < 22)
                    repeat ($urandom_range(8, 1))
                        send_event(make_event(2'($urandom_range(3)), 4'($urandom_range(15))));
                else
                    run_row_job();
            end
        end
    endtask

    initial
    begin
        send_gap_pct   = 7;
        recv_stall_pct = 76;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keypad_and_button();
        test_row_completion();
        test_longest_phases();
        test_random_jobs();
        settle_idle();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/srs_pkg.sv
design/srs_core.sv
design/timed_row_sowing_sequencer.sv
tb/sv/timed_row_sowing_sequencer_test.sv
